FILE: hw/rtl/pba_pkg.sv
package pba_pkg;

   // Fixed field widths of the request and response beats.
   localparam int TYPE_W     = 2;
   localparam int MAP_W      = 2;
   localparam int PORT_W     = 15;
   localparam int PORT_OUT_W = 10;

   // Width that holds any port number plus one word of headroom.
   localparam int PBASE_W = 16;

   // Fraction bits of the reciprocal used to split a port into word and bit.
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = 32;

   // The raw map never hands out a port.
   localparam logic [MAP_W-1:0] RAW_MAP = 2'd3;

   typedef enum logic [TYPE_W-1:0] {
      OP_QUERY  = 2'd0,
      OP_LOCK   = 2'd1,
      OP_UNLOCK = 2'd2,
      OP_ALLOC  = 2'd3
   } req_op_type;

   typedef enum logic [1:0] {
      RSP_NONE   = 2'd0,
      RSP_ACCESS = 2'd1,
      RSP_GRANT  = 2'd2
   } rsp_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        req_load;
      logic        decode_load;
      logic        fix_load;
      logic        index_load;
      logic        rd_issue;
      logic        scan_step;
      logic        access_commit;
      logic        grant_commit;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic alloc_op;
      logic alloc_ok;
      logic hit;
      logic exhausted;
   } dp_stat_type;

endpackage

FILE: hw/rtl/pba_ram.sv
module pba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 96
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/pba_ctrl.sv
module pba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output pba_pkg::dp_cmd_type  cmd,
   input  pba_pkg::dp_stat_type stat
);

   import pba_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_DIVFIX,
      S_INDEX,
      S_READ,
      S_UPDATE,
      S_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_strobe_ff;

   // Command decode and next state.
   always_comb begin
      cmd      = '0;
      cmd.rsp_sel = RSP_NONE;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode_load = 1'b1;
            if (!stat.alloc_op) begin
               state_in = S_DIVFIX;
            end else if (stat.alloc_ok) begin
               state_in = S_INDEX;
            end else begin
               // Allocation from a map without storage answers at once.
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_NONE;
               state_in     = S_IDLE;
            end
         end
         S_DIVFIX: begin
            cmd.fix_load = 1'b1;
            state_in     = S_INDEX;
         end
         S_INDEX: begin
            cmd.index_load = 1'b1;
            state_in       = stat.alloc_op ? S_SCAN : S_READ;
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.access_commit = 1'b1;
            cmd.rsp_load      = 1'b1;
            cmd.rsp_sel       = RSP_ACCESS;
            state_in          = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit) begin
               cmd.grant_commit = 1'b1;
               cmd.rsp_load     = 1'b1;
               cmd.rsp_sel      = RSP_GRANT;
               state_in         = S_IDLE;
            end else if (stat.exhausted) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = RSP_NONE;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

endmodule

FILE: hw/rtl/pba_dp.sv
module pba_dp #(
   parameter int NUM_PORTS = 1024,
   parameter int WORD_BITS = 32,
   parameter int NUM_MAPS  = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pba_pkg::TYPE_W-1:0]        req_type,
   input  logic [pba_pkg::MAP_W-1:0]         req_map_sel,
   input  logic [pba_pkg::PORT_W-1:0]        req_port,
   input  pba_pkg::dp_cmd_type               cmd,
   output pba_pkg::dp_stat_type              stat,
   output logic                              rsp_busy_res,
   output logic [pba_pkg::PORT_OUT_W-1:0]    rsp_port_out,
   output logic                              rsp_found
);

   import pba_pkg::*;

   localparam int WPM       = (NUM_PORTS + WORD_BITS - 1) / WORD_BITS;
   localparam int TOTAL     = NUM_MAPS * WPM;
   localparam int AW        = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int BIW       = $clog2(WORD_BITS);
   localparam int CW        = $clog2(WPM + 1);
   localparam int RECIP     = (1 << RECIP_SHIFT) / WORD_BITS;
   localparam int TAIL_BITS = NUM_PORTS - (WPM - 1) * WORD_BITS;
   // Bits of the last word that lie past the end of the map count as busy.
   localparam logic [WORD_BITS-1:0] TAIL_MASK =
      WORD_BITS'(~((64'd1 << TAIL_BITS) - 64'd1));

   // Request registers.
   req_op_type         op_ff;
   logic [MAP_W-1:0]   map_ff;
   logic [PORT_W-1:0]  port_ff;

   // Word and bit split of the port.
   logic [PROD_W-1:0]  prod;
   logic [PORT_W-1:0]  q0_in;
   logic [PORT_W-1:0]  q0_ff;
   logic [PBASE_W-1:0] rem;
   logic               rem_over;
   logic [PORT_W-1:0]  widx_in;
   logic [PORT_W-1:0]  widx_ff;
   logic [BIW-1:0]     bit_in;
   logic [BIW-1:0]     bit_ff;
   logic [AW-1:0]      base_in;
   logic [AW-1:0]      base_ff;
   logic               map_ok;
   logic               port_ok;
   logic               in_range;

   // Access address and scan pipeline.
   logic [AW-1:0]          addr_ff;
   logic [WORD_BITS-1:0]   mask_ff;
   logic [CW-1:0]          iss_cnt_ff;
   logic [PBASE_W-1:0]     iss_port_ff;
   logic                   iss_ok;
   logic                   ev_vld_ff;
   logic                   ev_last_ff;
   logic [AW-1:0]          ev_addr_ff;
   logic [PBASE_W-1:0]     ev_port_ff;

   // Word store and its valid bits.
   logic [TOTAL-1:0]       vld_ff;
   logic                   vld_rd_ff;
   logic                   rd_en;
   logic [WORD_BITS-1:0]   rd_data;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [WORD_BITS-1:0]   wr_data;
   logic                   access_wr;

   // Word evaluation.
   logic [WORD_BITS-1:0]   word_eff;
   logic [WORD_BITS-1:0]   scan_word;
   logic [WORD_BITS-1:0]   zero_bit;
   logic [BIW-1:0]         zero_idx;
   logic [PBASE_W-1:0]     grant_port;
   logic [WORD_BITS-1:0]   access_data;

   // Response registers.
   logic                   rsp_busy_ff;
   logic [PORT_OUT_W-1:0]  rsp_port_ff;
   logic                   rsp_found_ff;

   // Range checks on the held request.
   assign map_ok   = ({1'b0, map_ff} < 3'(NUM_MAPS));
   assign port_ok  = (PBASE_W'(port_ff) < PBASE_W'(NUM_PORTS));
   assign in_range = map_ok && port_ok;

   // Quotient estimate by reciprocal, low by at most one.
   assign prod    = PROD_W'(port_ff) * PROD_W'(RECIP);
   assign q0_in   = PORT_W'(prod >> RECIP_SHIFT);
   assign base_in = map_ok ? AW'(int'(map_ff) * WPM) : '0;

   // Remainder with one correction step.
   assign rem      = PBASE_W'(port_ff) - PBASE_W'(PROD_W'(q0_ff) * PROD_W'(WORD_BITS));
   assign rem_over = (rem >= PBASE_W'(WORD_BITS));
   assign widx_in  = rem_over ? (q0_ff + PORT_W'(1)) : q0_ff;
   assign bit_in   = rem_over ? BIW'(rem - PBASE_W'(WORD_BITS)) : BIW'(rem);

   // Request, decode and index registers.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff   <= req_op_type'(req_type);
         map_ff  <= req_map_sel;
         port_ff <= req_port;
      end
      if (cmd.decode_load) begin
         q0_ff   <= q0_in;
         base_ff <= base_in;
      end
      if (cmd.fix_load) begin
         widx_ff <= widx_in;
         bit_ff  <= bit_in;
      end
   end

   // A scan keeps issuing reads until every word of the map is out.
   assign iss_ok = (iss_cnt_ff != CW'(WPM));

   // Address register and scan pipeline.
   always_ff @(posedge clock) begin
      if (cmd.index_load) begin
         if (op_ff == OP_ALLOC) begin
            addr_ff <= base_ff;
         end else if (in_range) begin
            addr_ff <= base_ff + AW'(widx_ff);
         end else begin
            addr_ff <= '0;
         end
         mask_ff     <= WORD_BITS'(1) << bit_ff;
         iss_cnt_ff  <= '0;
         iss_port_ff <= '0;
         ev_vld_ff   <= 1'b0;
      end else if (cmd.scan_step) begin
         if (iss_ok) begin
            addr_ff     <= addr_ff + AW'(1);
            iss_cnt_ff  <= iss_cnt_ff + CW'(1);
            iss_port_ff <= iss_port_ff + PBASE_W'(WORD_BITS);
         end
         ev_vld_ff  <= iss_ok;
         ev_last_ff <= (iss_cnt_ff == CW'(WPM - 1));
         ev_addr_ff <= addr_ff;
         ev_port_ff <= iss_port_ff;
      end
   end

   // A word never written reads as all free.
   assign word_eff  = vld_rd_ff ? rd_data : '0;
   assign scan_word = word_eff | (ev_last_ff ? TAIL_MASK : '0);

   // Lowest free bit isolated as a one-hot, then encoded.
   assign zero_bit = ~scan_word & (scan_word + WORD_BITS'(1));

   always_comb begin
      zero_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (zero_bit[i]) begin
            zero_idx = zero_idx | BIW'(i);
         end
      end
   end

   assign grant_port = ev_port_ff + PBASE_W'(zero_idx);

   // Lock sets the bit, unlock clears it.
   assign access_data = (op_ff == OP_LOCK) ? (word_eff | mask_ff) : (word_eff & ~mask_ff);
   assign access_wr   = cmd.access_commit && in_range &&
                        ((op_ff == OP_LOCK) || (op_ff == OP_UNLOCK));

   // Read enable and write port selection.
   assign rd_en   = cmd.rd_issue || (cmd.scan_step && iss_ok);
   assign wr_en   = access_wr || cmd.grant_commit;
   assign wr_addr = cmd.grant_commit ? ev_addr_ff : addr_ff;
   assign wr_data = cmd.grant_commit ? (word_eff | zero_bit) : access_data;

   pba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (TOTAL)
   ) u_words (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Valid bits mark words written since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         vld_rd_ff <= vld_ff[addr_ff];
      end
   end

   // Response registers.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (cmd.rsp_sel)
            RSP_ACCESS: begin
               rsp_busy_ff  <= (op_ff == OP_QUERY) && in_range && (|(word_eff & mask_ff));
               rsp_port_ff  <= '0;
               rsp_found_ff <= 1'b0;
            end
            RSP_GRANT: begin
               rsp_busy_ff  <= 1'b0;
               rsp_port_ff  <= grant_port[PORT_OUT_W-1:0];
               rsp_found_ff <= 1'b1;
            end
            default: begin
               rsp_busy_ff  <= 1'b0;
               rsp_port_ff  <= '0;
               rsp_found_ff <= 1'b0;
            end
         endcase
      end
   end

   // Status toward the controller.
   assign stat.alloc_op  = (op_ff == OP_ALLOC);
   assign stat.alloc_ok  = map_ok && (map_ff != RAW_MAP);
   assign stat.hit       = ev_vld_ff && (scan_word != '1);
   assign stat.exhausted = ev_vld_ff && (scan_word == '1) && ev_last_ff;

   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_port_out = rsp_port_ff;
   assign rsp_found    = rsp_found_ff;

endmodule

FILE: hw/rtl/port_bitmap_allocator.sv
// Query, lock and unlock: decode, divide fix, index, read and update, then the response.
// Allocate on a map with storage: decode, index, then a scan that reads one bitmap word
// per cycle from the single read port of the word store; otherwise it answers at once.
// One request at a time; the next request is taken in the cycle the response shows.
// Reset clears all busy bits through per-word valid flags, so no clearing pass is run.
module port_bitmap_allocator #(
   parameter int NUM_PORTS = 1024,
   parameter int WORD_BITS = 32,
   parameter int NUM_MAPS  = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [pba_pkg::TYPE_W-1:0]        req_type,
   input  logic [pba_pkg::MAP_W-1:0]         req_map_sel,
   input  logic [pba_pkg::PORT_W-1:0]        req_port,
   output logic                              rsp_strobe,
   output logic                              rsp_busy_res,
   output logic [pba_pkg::PORT_OUT_W-1:0]    rsp_port_out,
   output logic                              rsp_found
);

   import pba_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer.
   pba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Bitmap store, address split and scan logic.
   pba_dp #(
      .NUM_PORTS (NUM_PORTS),
      .WORD_BITS (WORD_BITS),
      .NUM_MAPS  (NUM_MAPS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_type     (req_type),
      .req_map_sel  (req_map_sel),
      .req_port     (req_port),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_busy_res (rsp_busy_res),
      .rsp_port_out (rsp_port_out),
      .rsp_found    (rsp_found)
   );

`ifndef SYNTHESIS
   // An accepted request keeps the block occupied in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // Responses are single beats, never back to back.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   // A response without a grant carries port zero.
   a_no_grant_port: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_port_out == '0))
      else $error("nonzero port without a grant");

   // A busy answer and a grant never come in the same beat.
   a_busy_xor_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_busy_res && rsp_found))
      else $error("busy and found both set");
`endif

endmodule

FILE: bench/port_bitmap_allocator_test.sv
`timescale 1ns / 100ps

module port_bitmap_allocator_test;
   import pba_pkg::*;

   localparam int NUM_PORTS = 1024;
   localparam int NUM_MAPS  = 3;

   // Map codes; the raw map code comes from the package.
   localparam logic [MAP_W-1:0] MAP_SYSTEM   = 2'd0;
   localparam logic [MAP_W-1:0] MAP_STREAM   = 2'd1;
   localparam logic [MAP_W-1:0] MAP_DATAGRAM = 2'd2;

   // Covers any response beat still in flight, an allocate scan included.
   localparam int DRAIN_CYCLES = 48;

   typedef struct packed {
      logic                  busy_res;
      logic [PORT_OUT_W-1:0] port_out;
      logic                  found;
   } port_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [TYPE_W-1:0]     req_type = '0;
   logic [MAP_W-1:0]      req_map_sel = '0;
   logic [PORT_W-1:0]     req_port = '0;
   logic                  rsp_strobe;
   logic                  rsp_busy_res;
   logic [PORT_OUT_W-1:0] rsp_port_out;
   logic                  rsp_found;

   // Shadow copy of the busy bitmaps and the replies still owed by the block.
   bit [NUM_PORTS-1:0] port_busy [0:NUM_MAPS-1];
   port_reply_type     expected_replies [$];
   int                 error_count = 0;
   int                 burst_left = 0;

   port_bitmap_allocator #(
      .NUM_PORTS(NUM_PORTS),
      .WORD_BITS(32),
      .NUM_MAPS (NUM_MAPS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_map_sel (req_map_sel),
      .req_port    (req_port),
      .rsp_strobe  (rsp_strobe),
      .rsp_busy_res(rsp_busy_res),
      .rsp_port_out(rsp_port_out),
      .rsp_found   (rsp_found)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the shadow bitmaps and returns the reply it should get.
   function automatic port_reply_type apply_port_request(input req_op_type op,
                                                         input logic [MAP_W-1:0] map,
                                                         input logic [PORT_W-1:0] port);
      port_reply_type reply;
      bit             slot_ok;
      int             p;
      reply = '0;
      slot_ok = (map < NUM_MAPS) && (port < NUM_PORTS);
      case (op)
         OP_QUERY: begin
            if (slot_ok) reply.busy_res = port_busy[map][port];
         end
         OP_LOCK: begin
            if (slot_ok) port_busy[map][port] = 1'b1;
         end
         OP_UNLOCK: begin
            if (slot_ok) port_busy[map][port] = 1'b0;
         end
         default: begin
            // Lowest free port wins; the raw map and maps without storage never grant.
            if (map != RAW_MAP && map < NUM_MAPS) begin
               for (p = 0; p < NUM_PORTS && !reply.found; p++) begin
                  if (!port_busy[map][p]) begin
                     port_busy[map][p] = 1'b1;
                     reply.port_out = p[PORT_OUT_W-1:0];
                     reply.found = 1'b1;
                  end
               end
            end
         end
      endcase
      return reply;
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] want_val,
                                  input logic [15:0] got_val);
      error_count++;
      if (error_count <= 10)
         $display("Mismatch on %s at %0t: expected %0h, got %0h",
                  field, $time, want_val, got_val);
   endtask

   // Sends one request beat, with a random gap between bursts, and logs its reply.
   task automatic send_item(input req_op_type op, input logic [MAP_W-1:0] map,
                            input logic [PORT_W-1:0] port, output port_reply_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start       <= 1'b1;
      req_type    <= op;
      req_map_sel <= map;
      req_port    <= port;
      do @(posedge clock); while (busy !== 1'b0);
      want = apply_port_request(op, map, port);
      expected_replies.push_back(want);
   endtask

   // Lock, unlock, query and allocate on the system and stream maps, edge ports included.
   task automatic test_basic_ops();
      port_reply_type want;
      send_item(OP_QUERY,  MAP_SYSTEM, 15'd0,    want);
      send_item(OP_LOCK,   MAP_SYSTEM, 15'd0,    want);
      send_item(OP_QUERY,  MAP_SYSTEM, 15'd0,    want);
      send_item(OP_LOCK,   MAP_STREAM, 15'd1023, want);
      send_item(OP_QUERY,  MAP_STREAM, 15'd1023, want);
      send_item(OP_QUERY,  MAP_SYSTEM, 15'd1023, want);
      send_item(OP_ALLOC,  MAP_SYSTEM, 15'd0,    want);
      send_item(OP_ALLOC,  MAP_STREAM, 15'd32767, want);
      send_item(OP_UNLOCK, MAP_SYSTEM, 15'd0,    want);
      send_item(OP_ALLOC,  MAP_SYSTEM, 15'd100,  want);
      send_item(OP_UNLOCK, MAP_STREAM, 15'd1023, want);
      send_item(OP_QUERY,  MAP_STREAM, 15'd1023, want);
   endtask

   // Ports at or past the map size read as free and are ignored by lock and unlock.
   task automatic test_port_range();
      port_reply_type want;
      send_item(OP_LOCK,   MAP_SYSTEM, 15'd1024,  want);
      send_item(OP_QUERY,  MAP_SYSTEM, 15'd1024,  want);
      send_item(OP_LOCK,   MAP_STREAM, 15'd32767, want);
      send_item(OP_QUERY,  MAP_STREAM, 15'd32767, want);
      send_item(OP_UNLOCK, MAP_SYSTEM, 15'd32767, want);
      send_item(OP_QUERY,  MAP_SYSTEM, 15'd16384, want);
   endtask

   // The raw map has no storage here and never grants; datagram map starts empty.
   task automatic test_raw_map();
      port_reply_type want;
      send_item(OP_LOCK,   RAW_MAP,      15'd5, want);
      send_item(OP_QUERY,  RAW_MAP,      15'd5, want);
      send_item(OP_ALLOC,  RAW_MAP,      15'd5, want);
      send_item(OP_UNLOCK, RAW_MAP,      15'd5, want);
      send_item(OP_ALLOC,  MAP_DATAGRAM, 15'd0, want);
   endtask

   // Fill the datagram map by allocation, then free a few ports and take them back.
   task automatic test_map_full();
      port_reply_type want;
      bit             map_full;
      int             i;
      map_full = 1'b0;
      while (!map_full) begin
         if ($urandom_range(0, 7) == 0) begin
            send_item(OP_QUERY, MAP_DATAGRAM, PORT_W'($urandom_range(0, NUM_PORTS - 1)),
                      want);
         end else begin
            send_item(OP_ALLOC, MAP_DATAGRAM, PORT_W'($urandom_range(0, 32767)), want);
            map_full = !want.found;
         end
      end
      send_item(OP_ALLOC, MAP_DATAGRAM, PORT_W'($urandom_range(0, 32767)), want);
      send_item(OP_QUERY, MAP_DATAGRAM, 15'd1023, want);
      send_item(OP_LOCK,  MAP_DATAGRAM, 15'd1023, want);
      send_item(OP_UNLOCK, MAP_DATAGRAM, 15'd1023, want);
      for (i = 0; i < 6; i++)
         send_item(OP_UNLOCK, MAP_DATAGRAM, PORT_W'($urandom_range(0, NUM_PORTS - 1)),
                   want);
      for (i = 0; i < 9; i++)
         send_item(OP_ALLOC, MAP_DATAGRAM, PORT_W'($urandom_range(0, 32767)), want);
   endtask

   // Random mix over every operation and map, ports weighted toward the low words.
   task automatic test_random_mix(input int count);
      port_reply_type    want;
      req_op_type        op;
      logic [MAP_W-1:0]  map;
      logic [PORT_W-1:0] port;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2: op = OP_LOCK;
            3, 4:    op = OP_UNLOCK;
            5, 6:    op = OP_QUERY;
            default: op = OP_ALLOC;
         endcase
         map = MAP_W'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: port = PORT_W'($urandom_range(0, 95));
            4, 5, 6:    port = PORT_W'($urandom_range(0, NUM_PORTS - 1));
            7:          port = PORT_W'($urandom_range(NUM_PORTS - 8, NUM_PORTS + 7));
            default:    port = PORT_W'($urandom_range(0, 32767));
         endcase
         send_item(op, map, port, want);
      end
   endtask

   // Each response beat is checked against the oldest outstanding reply.
   always @(posedge clock) begin : check_replies
      port_reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_replies.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Unexpected response beat at %0t", $time);
         end else begin
            want = expected_replies.pop_front();
            if (rsp_busy_res !== want.busy_res)
               report_mismatch("busy_res", 16'(want.busy_res), 16'(rsp_busy_res));
            if (rsp_port_out !== want.port_out)
               report_mismatch("port_out", 16'(want.port_out), 16'(rsp_port_out));
            if (rsp_found !== want.found)
               report_mismatch("found", 16'(want.found), 16'(rsp_found));
         end
      end
   end

   // Main sequence.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_port_range();
      test_raw_map();
      test_map_full();
      test_random_mix(240);
      start <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog for a hung handshake or a missing response beat.
   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/pba_pkg.sv
hw/rtl/pba_ram.sv
hw/rtl/pba_ctrl.sv
hw/rtl/pba_dp.sv
hw/rtl/port_bitmap_allocator.sv
bench/port_bitmap_allocator_test.sv
